[hw/rtl/mcwu_pkg.sv]
// ----------------------------------------------------------------------------
// mcwu_pkg
// Shared types, command and status codes, and sizes for the mutex and
// condition-variable wakeup unit.
// ----------------------------------------------------------------------------
package mcwu_pkg;

    localparam int THREADS = 16;
    localparam int MUTEXES = 8;
    localparam int CONDS   = 8;

    // Scan positions wrap at THREADS, which is a power of two.
    localparam int POS_W   = $clog2(THREADS);
    localparam int MSEL_W  = $clog2(MUTEXES);
    localparam int CSEL_W  = $clog2(CONDS);

    // Command codes
    localparam logic [3:0] CMD_CREATE  = 4'd0;
    localparam logic [3:0] CMD_SUSPEND = 4'd1;
    localparam logic [3:0] CMD_RESUME  = 4'd2;
    localparam logic [3:0] CMD_MINIT   = 4'd3;
    localparam logic [3:0] CMD_LOCK    = 4'd4;
    localparam logic [3:0] CMD_UNLOCK  = 4'd5;
    localparam logic [3:0] CMD_CINIT   = 4'd6;
    localparam logic [3:0] CMD_WAIT    = 4'd7;
    localparam logic [3:0] CMD_SIGNAL  = 4'd8;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BLOCKED = 2'd1;
    localparam logic [1:0] STAT_UNDEF   = 2'd2;
    localparam logic [1:0] STAT_NOBODY  = 2'd3;

    typedef struct packed {
        logic [3:0] command;
        logic [3:0] thread_id;
        logic [2:0] mutex_sel;
        logic [2:0] cond_sel;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        woke_valid;
        logic [3:0]  woke_thread;
        logic [15:0] runnable_mask;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_PICK,
        ST_COMMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rotate;
        logic pick;
        logic commit;
    } dp_cmd_t;

endpackage

[hw/rtl/mcwu_ctrl.sv]
// ----------------------------------------------------------------------------
// mcwu_ctrl
// Sequencer: accept a command, step the datapath through rotate, pick and
// commit, and own the result valid flag.
// ----------------------------------------------------------------------------
module mcwu_ctrl
    import mcwu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t dp_cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        dp_cmd       = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dp_cmd.load = 1'b1;
                    state_next  = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                dp_cmd.rotate = 1'b1;
                state_next    = ST_PICK;
            end
            ST_PICK: begin
                dp_cmd.pick = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    dp_cmd.commit = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/mcwu_datapath.sv]
// ----------------------------------------------------------------------------
// mcwu_datapath
// Thread, mutex and condition state, round-robin waiter search and the
// result register.
// ----------------------------------------------------------------------------
module mcwu_datapath
    import mcwu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  dp_cmd_t dp_cmd,
    input  in_t     s_payload,
    output out_t    m_payload
);

    // Architectural state
    logic [THREADS-1:0] runnable_reg;
    logic [THREADS-1:0] defined_reg;
    logic               held_reg     [MUTEXES];
    logic [THREADS-1:0] lock_w_reg   [MUTEXES];
    logic [POS_W-1:0]   lock_pos_reg [MUTEXES];
    logic [THREADS-1:0] cond_w_reg   [CONDS];
    logic [POS_W-1:0]   cond_pos_reg [CONDS];

    // Per-command working registers
    in_t                cmd_reg;
    logic [THREADS-1:0] rot_reg;
    logic [POS_W-1:0]   base_reg;
    logic               found_reg;
    logic [POS_W-1:0]   who_reg;
    out_t               out_reg;

    logic [MSEL_W-1:0]  m;
    logic [CSEL_W-1:0]  c;
    logic [POS_W-1:0]   tid;

    assign m   = cmd_reg.mutex_sel[MSEL_W-1:0];
    assign c   = cmd_reg.cond_sel[CSEL_W-1:0];
    assign tid = cmd_reg.thread_id[POS_W-1:0];

    // Rotate stage: pick the waiter set and rotate it so the scan start is bit 0
    logic [THREADS-1:0]   src_w;
    logic [POS_W-1:0]     src_pos;
    logic [2*THREADS-1:0] dbl;

    always_comb begin
        if (cmd_reg.command == CMD_SIGNAL) begin
            src_w   = cond_w_reg[c];
            src_pos = cond_pos_reg[c];
        end else begin
            src_w   = lock_w_reg[m];
            src_pos = lock_pos_reg[m];
        end
        dbl = {src_w, src_w} >> src_pos;
    end

    // Pick stage: lowest set bit of the rotated set
    logic             any_set;
    logic [POS_W-1:0] first_off;

    always_comb begin
        any_set   = 1'b0;
        first_off = '0;
        for (int i = THREADS - 1; i >= 0; i--) begin
            if (rot_reg[i]) begin
                any_set   = 1'b1;
                first_off = POS_W'(i);
            end
        end
    end

    // Commit: next state of the addressed entries and the result
    logic               needs_tid, needs_m, needs_c, bad_tid, bad_sel;
    logic [THREADS-1:0] runnable_n, defined_n, lw_n, cw_n;
    logic               held_n;
    logic [POS_W-1:0]   lp_n, cp_n;
    logic [1:0]         status_n;
    logic               woke_n;
    logic [POS_W-1:0]   who_n;

    always_comb begin
        needs_tid = (cmd_reg.command <= CMD_RESUME) || (cmd_reg.command == CMD_LOCK) ||
                    (cmd_reg.command == CMD_WAIT);
        needs_m   = ((cmd_reg.command >= CMD_MINIT) && (cmd_reg.command <= CMD_UNLOCK)) ||
                    (cmd_reg.command == CMD_WAIT);
        needs_c   = (cmd_reg.command >= CMD_CINIT) && (cmd_reg.command <= CMD_SIGNAL);
        bad_tid   = needs_tid && !(int'(cmd_reg.thread_id) < THREADS);
        bad_sel   = (needs_m && (int'(cmd_reg.mutex_sel) >= MUTEXES)) ||
                    (needs_c && (int'(cmd_reg.cond_sel) >= CONDS));

        runnable_n = runnable_reg;
        defined_n  = defined_reg;
        held_n     = held_reg[m];
        lw_n       = lock_w_reg[m];
        lp_n       = lock_pos_reg[m];
        cw_n       = cond_w_reg[c];
        cp_n       = cond_pos_reg[c];
        status_n   = STAT_OK;
        woke_n     = 1'b0;
        who_n      = '0;

        if (bad_tid) begin
            status_n = STAT_UNDEF;
        end else if (!bad_sel) begin
            unique case (cmd_reg.command)
                CMD_CREATE: begin
                    defined_n[tid]  = 1'b1;
                    runnable_n[tid] = 1'b1;
                end
                CMD_SUSPEND, CMD_RESUME: begin
                    if (defined_reg[tid]) begin
                        runnable_n[tid] = (cmd_reg.command == CMD_RESUME);
                    end else begin
                        status_n = STAT_UNDEF;
                    end
                end
                CMD_MINIT: begin
                    held_n = 1'b0;
                    lw_n   = '0;
                    lp_n   = '0;
                end
                CMD_LOCK: begin
                    if (!held_reg[m]) begin
                        held_n   = 1'b1;
                        lw_n[tid] = 1'b0;
                    end else begin
                        if (defined_reg[tid]) begin
                            runnable_n[tid] = 1'b0;
                        end
                        lw_n[tid] = 1'b1;
                        status_n  = STAT_BLOCKED;
                    end
                end
                CMD_UNLOCK, CMD_WAIT: begin
                    held_n = 1'b0;
                    if (found_reg) begin
                        lw_n[who_reg] = 1'b0;
                        lp_n          = who_reg;
                        if (defined_reg[who_reg]) begin
                            runnable_n[who_reg] = 1'b1;
                        end
                        woke_n = 1'b1;
                        who_n  = who_reg;
                    end
                    // cond wait parks the caller after releasing the mutex
                    if (cmd_reg.command == CMD_WAIT) begin
                        cw_n[tid] = 1'b1;
                        if (defined_reg[tid]) begin
                            runnable_n[tid] = 1'b0;
                        end
                    end
                end
                CMD_CINIT: begin
                    cw_n = '0;
                    cp_n = '0;
                end
                CMD_SIGNAL: begin
                    if (found_reg) begin
                        cw_n[who_reg] = 1'b0;
                        cp_n          = who_reg;
                        if (defined_reg[who_reg]) begin
                            runnable_n[who_reg] = 1'b1;
                        end
                        woke_n = 1'b1;
                        who_n  = who_reg;
                    end else begin
                        status_n = STAT_NOBODY;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            cmd_reg <= s_payload;
        end
        if (dp_cmd.rotate) begin
            rot_reg  <= dbl[THREADS-1:0];
            base_reg <= src_pos;
        end
        if (dp_cmd.pick) begin
            found_reg <= any_set;
            // wraps at THREADS
            who_reg   <= base_reg + first_off;
        end
        if (dp_cmd.commit) begin
            out_reg.status        <= status_n;
            out_reg.woke_valid    <= woke_n;
            out_reg.woke_thread   <= 4'(who_n);
            out_reg.runnable_mask <= 16'(runnable_n);
        end
    end

    // Architectural state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            runnable_reg <= '0;
            defined_reg  <= '0;
            for (int i = 0; i < MUTEXES; i++) begin
                held_reg[i]     <= 1'b0;
                lock_w_reg[i]   <= '0;
                lock_pos_reg[i] <= '0;
            end
            for (int i = 0; i < CONDS; i++) begin
                cond_w_reg[i]   <= '0;
                cond_pos_reg[i] <= '0;
            end
        end else if (dp_cmd.commit) begin
            runnable_reg    <= runnable_n;
            defined_reg     <= defined_n;
            held_reg[m]     <= held_n;
            lock_w_reg[m]   <= lw_n;
            lock_pos_reg[m] <= lp_n;
            cond_w_reg[c]   <= cw_n;
            cond_pos_reg[c] <= cp_n;
        end
    end

    assign m_payload = out_reg;

endmodule

[hw/rtl/mutex_condvar_wakeup_unit_core.sv]
// ----------------------------------------------------------------------------
// mutex_condvar_wakeup_unit_core
// Hardware lock unit: thread run state, round-robin mutexes and condition
// variables.
// ----------------------------------------------------------------------------
// Each command transfer on s_ produces exactly one result transfer on m_.
// A command goes from acceptance to result in these steps: capture it, rotate
// the addressed waiter set so the scan position sits at bit 0, find the first
// waiting thread at or after the scan position, commit the state update and
// load the result register. The sequencer handles one command at a time: a
// new one is accepted once the previous one has committed, even while the
// previous result still waits on m_, but the new commit stalls until that
// result has been taken. A lock on a held mutex returns status blocked and
// parks the caller; the caller retries after it is woken. Unlock, cond wait
// and signal report the woken thread in woke_valid and woke_thread. Thread,
// mutex and condition state clears on reset, with no extra initialization time.
// ----------------------------------------------------------------------------
module mutex_condvar_wakeup_unit_core
    import mcwu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,

    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,

    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    // Command strobes from the sequencer to the datapath
    dp_cmd_t dp_cmd;

    // Sequencer: capture, rotate, pick, commit
    mcwu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd)
    );

    // State tables, waiter search and result register
    mcwu_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_cmd    (dp_cmd),
        .s_payload (s_payload),
        .m_payload (m_payload)
    );

endmodule

[hw/rtl/mcwu_checker.sv]
// ----------------------------------------------------------------------------
// mcwu_checker
// Port-level checks for the wakeup unit, bound to the top level.
// ----------------------------------------------------------------------------
module mcwu_checker
    import mcwu_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    // one command in flight: s_ready stays low after an accept while the command rotates and picks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready ##1 !s_ready)
        else $error("input accepted while a command is still in flight");

    a_woke_thread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.woke_valid) |-> (m_payload.woke_thread == '0))
        else $error("woke_thread nonzero without a wakeup");

    a_no_wake_on_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_payload.status == STAT_BLOCKED) ||
                     (m_payload.status == STAT_NOBODY) ||
                     (m_payload.status == STAT_UNDEF))) |-> !m_payload.woke_valid)
        else $error("wakeup reported with a failing status");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("result dropped or changed while stalled");

endmodule

bind mutex_condvar_wakeup_unit_core mcwu_checker u_mcwu_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mutex and condition-variable wakeup unit.
// ----------------------------------------------------------------------------
// Commands go in on the s_ channel and results come out on the m_ channel.
// Both channels idle at random between transfers, with calm stretches where
// neither side idles. A short table of directed commands runs first; a few of
// its rows carry a hand-typed result, and the rest are checked against an
// in-bench model of the unit. Random lock, contend, unlock, wait and signal
// sequences follow, mixed with unstructured commands.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcwu_pkg::*;

    localparam int          RANDOM_ITEMS  = 2000;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;

    mutex_condvar_wakeup_unit_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Shadow copy of the unit's state, advanced at every command transfer.
    bit [15:0] run_bits;
    bit [15:0] def_bits;
    bit        mtx_held   [MUTEXES];
    bit [15:0] mtx_waiting[MUTEXES];
    bit [3:0]  mtx_scan   [MUTEXES];
    bit [15:0] cv_waiting [CONDS];
    bit [3:0]  cv_scan    [CONDS];

    out_t        pending_results[$];
    int          error_count = 0;
    int          items_sent  = 0;
    int unsigned cycle_count = 0;
    bit          send_calm   = 1'b0;
    bit          take_calm   = 1'b0;

    // Directed table: command plus an optional hand-typed result.
    typedef struct {
        in_t  cmd;
        bit   typed;
        out_t want;
    } step_t;

    step_t directed_steps[$];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time,
                     pending_results.size());
            $display("mutex_condvar_wakeup_unit_core test failed");
            $finish;
        end
    end

    // Round-robin search: first set bit at or after the scan position.
    function automatic bit find_waiter(input bit [15:0] waiting, input bit [3:0] scan,
                                       output bit [3:0] who);
        bit [3:0] idx;
        who = '0;
        for (int k = 0; k < THREADS; k++) begin
            idx = scan + 4'(k);
            if (waiting[idx]) begin
                who = idx;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the shadow state by one command and return the result it owes.
    function automatic out_t predict_wakeup(input in_t cmd);
        out_t     res;
        bit       found;
        bit [3:0] who;
        bit [3:0] t;
        bit [2:0] m;
        bit [2:0] c;
        res    = '0;
        found  = 1'b0;
        who    = '0;
        t      = cmd.thread_id;
        m      = cmd.mutex_sel;
        c      = cmd.cond_sel;
        res.status = STAT_OK;
        case (cmd.command)
            CMD_CREATE: begin
                def_bits[t] = 1'b1;
                run_bits[t] = 1'b1;
            end
            CMD_SUSPEND, CMD_RESUME: begin
                if (def_bits[t])
                    run_bits[t] = (cmd.command == CMD_RESUME);
                else
                    res.status = STAT_UNDEF;
            end
            CMD_MINIT: begin
                mtx_held[m]    = 1'b0;
                mtx_waiting[m] = '0;
                mtx_scan[m]    = '0;
            end
            CMD_LOCK: begin
                if (!mtx_held[m]) begin
                    mtx_held[m]       = 1'b1;
                    mtx_waiting[m][t] = 1'b0;
                end else begin
                    // Park the caller, even when it already holds the mutex.
                    if (def_bits[t])
                        run_bits[t] = 1'b0;
                    mtx_waiting[m][t] = 1'b1;
                    res.status        = STAT_BLOCKED;
                end
            end
            CMD_UNLOCK, CMD_WAIT: begin
                mtx_held[m] = 1'b0;
                found = find_waiter(mtx_waiting[m], mtx_scan[m], who);
                if (found) begin
                    mtx_waiting[m][who] = 1'b0;
                    mtx_scan[m]         = who;
                    if (def_bits[who])
                        run_bits[who] = 1'b1;
                end
                // Wait parks the caller after the release, even if it was just woken.
                if (cmd.command == CMD_WAIT) begin
                    cv_waiting[c][t] = 1'b1;
                    if (def_bits[t])
                        run_bits[t] = 1'b0;
                end
            end
            CMD_CINIT: begin
                cv_waiting[c] = '0;
                cv_scan[c]    = '0;
            end
            CMD_SIGNAL: begin
                found = find_waiter(cv_waiting[c], cv_scan[c], who);
                if (found) begin
                    cv_waiting[c][who] = 1'b0;
                    cv_scan[c]         = who;
                    if (def_bits[who])
                        run_bits[who] = 1'b1;
                end else begin
                    res.status = STAT_NOBODY;
                end
            end
            default: ;
        endcase
        res.woke_valid    = found;
        res.woke_thread   = found ? who : 4'd0;
        res.runnable_mask = run_bits;
        return res;
    endfunction

    // Drive one command, hold it until the transfer, then log what it owes.
    task automatic push_cmd(input in_t cmd, input bit typed, input out_t want);
        int   gap;
        out_t predicted;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= cmd;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_wakeup(cmd);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic issue(input logic [3:0] op, input logic [3:0] tid,
                         input logic [2:0] m, input logic [2:0] c);
        in_t cmd;
        cmd.command   = op;
        cmd.thread_id = tid;
        cmd.mutex_sel = m;
        cmd.cond_sel  = c;
        push_cmd(cmd, 1'b0, '0);
    endtask

    task automatic add_step(input logic [3:0] op, input logic [3:0] tid,
                            input logic [2:0] m, input logic [2:0] c, input bit typed,
                            input logic [1:0] st, input logic [15:0] mask);
        step_t s;
        s.cmd.command           = op;
        s.cmd.thread_id         = tid;
        s.cmd.mutex_sel         = m;
        s.cmd.cond_sel          = c;
        s.typed                 = typed;
        s.want.status           = st;
        s.want.woke_valid       = 1'b0;
        s.want.woke_thread      = 4'd0;
        s.want.runnable_mask    = mask;
        directed_steps.push_back(s);
    endtask

    // Compare one result transfer with the oldest pending result.
    task automatic check_result(input out_t got);
        out_t want;
        bit   bad;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing pending: got %h", $time, got);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        bad  = 1'b0;
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            bad = 1'b1;
        end
        if (got.woke_valid !== want.woke_valid) begin
            $display("%0t: woke_valid expected %0b got %0b", $time,
                     want.woke_valid, got.woke_valid);
            bad = 1'b1;
        end
        if (got.woke_thread !== want.woke_thread) begin
            $display("%0t: woke_thread expected %0d got %0d", $time,
                     want.woke_thread, got.woke_thread);
            bad = 1'b1;
        end
        if (got.runnable_mask !== want.runnable_mask) begin
            $display("%0t: runnable_mask expected %h got %h", $time,
                     want.runnable_mask, got.runnable_mask);
            bad = 1'b1;
        end
        if (bad)
            error_count++;
    endtask

    // Result side: stall at random, then take the next transfer and check it.
    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0)
                take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_result(m_payload);
        end
    end

    // Command side: reset, directed table, random sequences, drain, verdict.
    initial begin
        logic [3:0] owner;
        logic [3:0] op;
        logic [2:0] m;
        logic [2:0] c;
        int         roll;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        run_bits  = '0;
        def_bits  = '0;
        for (int i = 0; i < MUTEXES; i++) begin
            mtx_held[i]    = 1'b0;
            mtx_waiting[i] = '0;
            mtx_scan[i]    = '0;
        end
        for (int i = 0; i < CONDS; i++) begin
            cv_waiting[i] = '0;
            cv_scan[i]    = '0;
        end

        // Fresh after reset: nothing defined, nothing waiting.
        add_step(CMD_SIGNAL,    4'd15, 3'd0, 3'd0, 1'b1, STAT_NOBODY, 16'h0000);
        add_step(CMD_SUSPEND,   4'd5,  3'd0, 3'd0, 1'b1, STAT_UNDEF,  16'h0000);
        add_step(CMD_RESUME,    4'd0,  3'd0, 3'd0, 1'b1, STAT_UNDEF,  16'h0000);
        add_step(CMD_UNLOCK,    4'd0,  3'd7, 3'd0, 1'b1, STAT_OK,     16'h0000);
        add_step(CMD_UNUSED_HI, 4'd15, 3'd7, 3'd7, 1'b1, STAT_OK,     16'h0000);
        add_step(CMD_CREATE,    4'd0,  3'd0, 3'd0, 1'b1, STAT_OK,     16'h0001);
        add_step(CMD_CREATE,    4'd15, 3'd0, 3'd0, 1'b1, STAT_OK,     16'h8001);
        // Contention, a recursive lock and a waiter that was never created.
        add_step(CMD_CREATE,    4'd3,  3'd0, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_LOCK,      4'd0,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_LOCK,      4'd15, 3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_LOCK,      4'd0,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_LOCK,      4'd9,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_UNLOCK,    4'd0,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_UNLOCK,    4'd0,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        // Condition wait and signal, including a waiter woken from the mutex.
        add_step(CMD_LOCK,      4'd3,  3'd0, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_WAIT,      4'd3,  3'd0, 3'd7, 1'b0, STAT_OK, '0);
        add_step(CMD_WAIT,      4'd15, 3'd7, 3'd7, 1'b0, STAT_OK, '0);
        add_step(CMD_SIGNAL,    4'd0,  3'd0, 3'd7, 1'b0, STAT_OK, '0);
        add_step(CMD_SIGNAL,    4'd0,  3'd0, 3'd7, 1'b0, STAT_OK, '0);
        add_step(CMD_SIGNAL,    4'd0,  3'd0, 3'd7, 1'b0, STAT_OK, '0);
        // Init clears held flag, waiters and scan positions.
        add_step(CMD_LOCK,      4'd3,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_LOCK,      4'd0,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_MINIT,     4'd0,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_UNLOCK,    4'd0,  3'd7, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_WAIT,      4'd0,  3'd1, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_CINIT,     4'd0,  3'd0, 3'd0, 1'b0, STAT_OK, '0);
        add_step(CMD_SIGNAL,    4'd0,  3'd0, 3'd0, 1'b0, STAT_OK, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i])
            push_cmd(directed_steps[i].cmd, directed_steps[i].typed, directed_steps[i].want);

        while (items_sent < RANDOM_ITEMS + directed_steps.size()) begin
            roll = $urandom_range(0, 99);
            // Favor two mutexes so that contention builds up.
            m = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, 1));
            c = 3'($urandom_range(0, 7));
            if (roll < 60) begin
                // Well-formed: lock, contend, then release or wait and signal.
                owner = 4'($urandom_range(0, 15));
                if (!def_bits[owner] && $urandom_range(0, 7) != 0)
                    issue(CMD_CREATE, owner, m, c);
                issue(CMD_LOCK, owner, m, c);
                repeat ($urandom_range(0, 3))
                    issue(CMD_LOCK, 4'($urandom_range(0, 15)), m, c);
                if ($urandom_range(0, 1) == 0) begin
                    issue(CMD_UNLOCK, 4'($urandom_range(0, 15)), m, c);
                end else begin
                    issue(CMD_WAIT, owner, m, c);
                    repeat ($urandom_range(1, 2))
                        issue(CMD_SIGNAL, 4'($urandom_range(0, 15)), m, c);
                end
            end else begin
                // Noise: any command, any fields, unused codes included.
                op = 4'($urandom_range(0, 9));
                if (op > CMD_SIGNAL)
                    op = 4'($urandom_range(CMD_SIGNAL + 1, CMD_UNUSED_HI));
                issue(op, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), c);
            end
        end

        @(posedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        // Give any stray result time to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("mutex_condvar_wakeup_unit_core test passed");
        end else begin
            $display("mutex_condvar_wakeup_unit_core test failed");
        end
        $finish;
    end

endmodule
